// ===== hdl/midpoint_circle_span_generator_defines.svh =====
// Assertion macros for the circle span generator checkers.
// Both expect signals named clock and reset in the asserting scope.
`ifndef MIDPOINT_CIRCLE_SPAN_GENERATOR_DEFINES_SVH
`define MIDPOINT_CIRCLE_SPAN_GENERATOR_DEFINES_SVH

// Checked outside reset only.
`define MCSG_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define MCSG_CHECK_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/mcsg_pkg.sv =====
package mcsg_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int COLOR_BITS     = 18;
   localparam int CSR_IDX_BITS   = 2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_X_LIMIT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_LIMIT = 2'd1;

   localparam int X_LIMIT_RST = 319;
   localparam int Y_LIMIT_RST = 239;

   // Item modes
   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   // Midpoint recurrence constants
   localparam int DEC_INIT = 3;
   localparam int DEC_DIAG = 10;
   localparam int DEC_AXIS = 6;

   // Phase that closes one walk step
   localparam logic [1:0] FILL_LAST_PHASE = 2'd3;
   localparam logic [2:0] RING_LAST_PHASE = 3'd7;

   typedef struct packed {
      logic give;   // this item yields a span
      logic last;   // span closes the circle
   } span_ctl_type;

endpackage

// ===== hdl/midpoint_circle_span_generator.sv =====
// Midpoint circle span generator.
// req channel: one item per handshake (req_valid high, req_stall low at a
// rising edge). A start item (mode 0) loads center, radius, color and fill
// flag and gives no span. Each advance item (mode 1) gives one span while a
// circle is running and nothing otherwise.
// rsp channel: a span is taken at an edge with rsp_valid high and rsp_stall
// low; rsp_last_span marks the final span of the circle.
// csr port: x_limit (index 0) and y_limit (index 1) clamp filled spans;
// write them only while no item is in flight.
// Path: an accepted item waits in the input register, the walk forms its
// span combinationally, and the result register holds it for rsp.
// Throughput: one item per cycle while no span is held by rsp_stall; the
// input register and the result register each hold one item, and the walk
// state updates in the same cycle the item leaves the input register.
// Stall: while rsp_stall holds a span, the input register still takes one
// more item, then req_stall rises until the span is taken.
// Reset clears both registers and the walk (idle), limits go to 319 and 239.
module midpoint_circle_span_generator #(
   parameter int COORD_BITS = mcsg_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic signed [COORD_BITS-1:0]      req_center_x,
   input  logic signed [COORD_BITS-1:0]      req_center_y,
   input  logic [COORD_BITS-2:0]             req_radius,
   input  logic [mcsg_pkg::COLOR_BITS-1:0]   req_draw_color,
   input  logic                              req_fill_on,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [COORD_BITS:0]        rsp_left_x,
   output logic signed [COORD_BITS:0]        rsp_right_x,
   output logic signed [COORD_BITS:0]        rsp_row_y,
   output logic [mcsg_pkg::COLOR_BITS-1:0]   rsp_pixel_color,
   output logic                              rsp_last_span,
   input  logic                              csr_wr_en,
   input  logic [mcsg_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]             csr_wr_data
);
   import mcsg_pkg::*;

   logic                         in_vld_ff, in_vld_in;
   logic                         mode_ff, fill_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [COORD_BITS-2:0]        radius_ff;
   logic [COLOR_BITS-1:0]        color_ff;

   logic                         out_vld_ff, out_vld_in;
   logic signed [COORD_BITS:0]   left_ff, right_ff, row_ff;
   logic [COLOR_BITS-1:0]        pix_ff;
   logic                         last_ff;

   logic                         out_free, in_free, fire, take_req;
   logic [COORD_BITS-1:0]        x_limit, y_limit;
   span_ctl_type                 span_ctl;
   logic signed [COORD_BITS:0]   left_x, right_x, row_y;
   logic [COLOR_BITS-1:0]        pixel_color;

   assign out_free = !out_vld_ff || !rsp_stall;
   assign in_free  = !in_vld_ff || out_free;
   assign fire     = in_vld_ff && out_free;
   assign take_req = req_valid && in_free;

   assign in_vld_in  = in_free ? req_valid : in_vld_ff;
   assign out_vld_in = out_free ? span_ctl.give : out_vld_ff;

   mcsg_csr #(.COORD_BITS(COORD_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .x_limit     (x_limit),
      .y_limit     (y_limit)
   );

   mcsg_walk #(.COORD_BITS(COORD_BITS)) u_walk (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .mode        (mode_ff),
      .center_x    (cx_ff),
      .center_y    (cy_ff),
      .radius      (radius_ff),
      .draw_color  (color_ff),
      .fill_on     (fill_ff),
      .x_limit     (x_limit),
      .y_limit     (y_limit),
      .span_ctl    (span_ctl),
      .left_x      (left_x),
      .right_x     (right_x),
      .row_y       (row_y),
      .pixel_color (pixel_color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // input item register
   always_ff @(posedge clock) begin
      if (take_req) begin
         mode_ff   <= req_mode;
         cx_ff     <= req_center_x;
         cy_ff     <= req_center_y;
         radius_ff <= req_radius;
         color_ff  <= req_draw_color;
         fill_ff   <= req_fill_on;
      end
   end

   // result register; hold while stalled
   always_ff @(posedge clock) begin
      if (out_free && span_ctl.give) begin
         left_ff  <= left_x;
         right_ff <= right_x;
         row_ff   <= row_y;
         pix_ff   <= pixel_color;
         last_ff  <= span_ctl.last;
      end
   end

   assign req_stall       = !in_free;
   assign rsp_valid       = out_vld_ff;
   assign rsp_left_x      = left_ff;
   assign rsp_right_x     = right_ff;
   assign rsp_row_y       = row_ff;
   assign rsp_pixel_color = pix_ff;
   assign rsp_last_span   = last_ff;

endmodule

// ===== hdl/mcsg_csr.sv =====
module mcsg_csr #(
   parameter int COORD_BITS = mcsg_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [mcsg_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]             csr_wr_data,
   output logic [COORD_BITS-1:0]             x_limit,
   output logic [COORD_BITS-1:0]             y_limit
);
   import mcsg_pkg::*;

   logic [COORD_BITS-1:0] x_limit_ff;
   logic [COORD_BITS-1:0] y_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= COORD_BITS'(X_LIMIT_RST);
         y_limit_ff <= COORD_BITS'(Y_LIMIT_RST);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_X_LIMIT: x_limit_ff <= csr_wr_data;
            CSR_Y_LIMIT: y_limit_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   assign x_limit = x_limit_ff;
   assign y_limit = y_limit_ff;

endmodule

// ===== hdl/mcsg_walk.sv =====
module mcsg_walk #(
   parameter int COORD_BITS = mcsg_pkg::COORD_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic                            mode,
   input  logic signed [COORD_BITS-1:0]    center_x,
   input  logic signed [COORD_BITS-1:0]    center_y,
   input  logic [COORD_BITS-2:0]           radius,
   input  logic [mcsg_pkg::COLOR_BITS-1:0] draw_color,
   input  logic                            fill_on,
   input  logic [COORD_BITS-1:0]           x_limit,
   input  logic [COORD_BITS-1:0]           y_limit,
   output mcsg_pkg::span_ctl_type          span_ctl,
   output logic signed [COORD_BITS:0]      left_x,
   output logic signed [COORD_BITS:0]      right_x,
   output logic signed [COORD_BITS:0]      row_y,
   output logic [mcsg_pkg::COLOR_BITS-1:0] pixel_color
);
   import mcsg_pkg::*;

   localparam int OFF_BITS = COORD_BITS + 1;
   localparam int SUM_BITS = COORD_BITS + 2;
   localparam int DEC_BITS = COORD_BITS + 4;

   function automatic logic signed [SUM_BITS-1:0] clamp_lim(
      input logic signed [SUM_BITS-1:0] v,
      input logic [COORD_BITS-1:0]      lim
   );
      logic signed [SUM_BITS-1:0] lim_s;
      lim_s = $signed({2'b00, lim});
      if (v < 0)
         return '0;
      else if (v > lim_s)
         return lim_s;
      else
         return v;
   endfunction

   logic signed [COORD_BITS-1:0] ctr_x_ff, ctr_y_ff;
   logic signed [OFF_BITS-1:0]   off_x_ff, off_y_ff;
   logic signed [DEC_BITS-1:0]   dec_ff;
   logic [2:0]                   phase_ff;
   logic [COLOR_BITS-1:0]        color_ff;
   logic                         fill_ff;
   logic                         running_ff;

   logic                         swap, a_neg, b_neg, end_step, diag, give, done;
   logic signed [OFF_BITS-1:0]   a_mag, b_mag, ox_in, oy_dn, oy_in;
   logic signed [SUM_BITS-1:0]   cx_s, cy_s, a_s, b_s, a_sgn, b_sgn;
   logic signed [SUM_BITS-1:0]   sum_r, sum_l, row_raw, left_s, right_s, row_s;
   logic signed [DEC_BITS-1:0]   ox_d, oy_d, dec_diag, dec_axis, dec_start;

   always_comb begin
      swap  = fill_ff ? phase_ff[1] : phase_ff[2];
      a_mag = swap ? off_y_ff : off_x_ff;
      b_mag = swap ? off_x_ff : off_y_ff;
      a_neg = !fill_ff && phase_ff[0];
      b_neg = fill_ff ? phase_ff[0] : phase_ff[1];

      cx_s  = $signed({{2{ctr_x_ff[COORD_BITS-1]}}, ctr_x_ff});
      cy_s  = $signed({{2{ctr_y_ff[COORD_BITS-1]}}, ctr_y_ff});
      a_s   = $signed({a_mag[OFF_BITS-1], a_mag});
      b_s   = $signed({b_mag[OFF_BITS-1], b_mag});
      a_sgn = a_neg ? -a_s : a_s;
      b_sgn = b_neg ? -b_s : b_s;

      sum_r   = cx_s + a_sgn;
      sum_l   = fill_ff ? (cx_s - a_s) : sum_r;
      row_raw = cy_s + b_sgn;

      // clamp only filled spans
      left_s  = fill_ff ? clamp_lim(sum_l, x_limit) : sum_l;
      right_s = fill_ff ? clamp_lim(sum_r, x_limit) : sum_r;
      row_s   = fill_ff ? clamp_lim(row_raw, y_limit) : row_raw;

      end_step = fill_ff ? (phase_ff[1:0] == FILL_LAST_PHASE)
                         : (phase_ff == RING_LAST_PHASE);

      // midpoint step
      ox_in    = off_x_ff + OFF_BITS'(1);
      oy_dn    = off_y_ff - OFF_BITS'(1);
      diag     = !dec_ff[DEC_BITS-1];
      oy_in    = diag ? oy_dn : off_y_ff;
      ox_d     = DEC_BITS'(ox_in);
      oy_d     = DEC_BITS'(oy_dn);
      dec_diag = dec_ff + ((ox_d - oy_d) <<< 2) + DEC_BITS'(DEC_DIAG);
      dec_axis = dec_ff + (ox_d <<< 2) + DEC_BITS'(DEC_AXIS);
      done     = oy_in < ox_in;

      dec_start = DEC_BITS'(DEC_INIT)
                - $signed({{(DEC_BITS-COORD_BITS){1'b0}}, radius, 1'b0});

      give = fire && (mode == MODE_ADVANCE) && running_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_x_ff   <= '0;
         ctr_y_ff   <= '0;
         off_x_ff   <= '0;
         off_y_ff   <= '0;
         dec_ff     <= '0;
         phase_ff   <= '0;
         color_ff   <= '0;
         fill_ff    <= 1'b0;
         running_ff <= 1'b0;
      end else if (fire && (mode == MODE_START)) begin
         // load a new circle, dropping any walk in progress
         ctr_x_ff   <= center_x;
         ctr_y_ff   <= center_y;
         off_x_ff   <= '0;
         off_y_ff   <= $signed({2'b00, radius});
         dec_ff     <= dec_start;
         phase_ff   <= '0;
         color_ff   <= draw_color;
         fill_ff    <= fill_on;
         running_ff <= 1'b1;
      end else if (give) begin
         if (end_step) begin
            off_x_ff   <= ox_in;
            off_y_ff   <= oy_in;
            dec_ff     <= diag ? dec_diag : dec_axis;
            phase_ff   <= '0;
            running_ff <= !done;
         end else begin
            phase_ff <= phase_ff + 3'd1;
         end
      end
   end

   assign span_ctl.give = give;
   assign span_ctl.last = end_step && done;
   assign left_x        = left_s[COORD_BITS:0];
   assign right_x       = right_s[COORD_BITS:0];
   assign row_y         = row_s[COORD_BITS:0];
   assign pixel_color   = color_ff;

endmodule

// ===== hdl/mcsg_checker.sv =====
`include "midpoint_circle_span_generator_defines.svh"

module mcsg_checker #(
   parameter int COORD_BITS = mcsg_pkg::COORD_BITS_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [COORD_BITS:0]        rsp_left_x,
   input logic signed [COORD_BITS:0]        rsp_right_x,
   input logic signed [COORD_BITS:0]        rsp_row_y,
   input logic [mcsg_pkg::COLOR_BITS-1:0]   rsp_pixel_color,
   input logic                              rsp_last_span
);

   localparam int SPAN_BITS = 3 * (COORD_BITS + 1) + mcsg_pkg::COLOR_BITS + 1;

   logic [SPAN_BITS-1:0] rsp_bits;

   assign rsp_bits = {rsp_left_x, rsp_right_x, rsp_row_y, rsp_pixel_color, rsp_last_span};

   // back-pressure comes only from a held span
   `MCSG_CHECK(a_stall_src, req_stall |-> (rsp_valid && rsp_stall), "req_stall without held span")

   // a span never runs right to left
   `MCSG_CHECK(a_span_order, rsp_valid |-> (rsp_left_x <= rsp_right_x), "left_x beyond right_x")

   // both channels come out of reset empty
   `MCSG_CHECK_RST(a_reset_idle, reset |=> (!rsp_valid && !req_stall), "busy after reset")

   `MCSG_CHECK(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_bits)), "stalled span changed")

endmodule

bind midpoint_circle_span_generator mcsg_checker #(.COORD_BITS(COORD_BITS)) u_mcsg_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import mcsg_pkg::*;

   localparam int CB          = COORD_BITS_DEF;
   localparam int STUCK_LIMIT = 2000;

   // indexes that decode to no register
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic                  mode;
      logic [CB-1:0]         center_x;
      logic [CB-1:0]         center_y;
      logic [CB-2:0]         radius;
      logic [COLOR_BITS-1:0] draw_color;
      logic                  fill_on;
      logic                  drain;     // hold until every span is back
   } circle_req_type;

   typedef struct packed {
      logic [CB:0]           left_x;
      logic [CB:0]           right_x;
      logic [CB:0]           row_y;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  last_span;
   } span_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic                          req_mode       = 1'b0;
   logic signed [CB-1:0]          req_center_x   = '0;
   logic signed [CB-1:0]          req_center_y   = '0;
   logic [CB-2:0]                 req_radius     = '0;
   logic [COLOR_BITS-1:0]         req_draw_color = '0;
   logic                          req_fill_on    = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic signed [CB:0]            rsp_left_x;
   logic signed [CB:0]            rsp_right_x;
   logic signed [CB:0]            rsp_row_y;
   logic [COLOR_BITS-1:0]         rsp_pixel_color;
   logic                          rsp_last_span;
   logic                          csr_wr_en      = 1'b0;
   logic [CSR_IDX_BITS-1:0]       csr_index      = '0;
   logic [CB-1:0]                 csr_wr_data    = '0;

   always #5 clock = ~clock;

   midpoint_circle_span_generator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius      (req_radius),
      .req_draw_color  (req_draw_color),
      .req_fill_on     (req_fill_on),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_left_x      (rsp_left_x),
      .rsp_right_x     (rsp_right_x),
      .rsp_row_y       (rsp_row_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_span   (rsp_last_span),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   circle_req_type pending_q[$];
   span_type       span_q[$];
   circle_req_type cur_req;
   int             queued_total = 0;
   int             req_count    = 0;
   int             err_count    = 0;
   int             stuck_cycles = 0;
   bit             quiet        = 1'b0;

   // walk state of the circle under prediction
   int                    ctr_col, ctr_row, step_x, step_y, dec_val, phase;
   int                    lim_x, lim_y;
   logic [COLOR_BITS-1:0] hold_color;
   bit                    hold_fill, walking;

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      err_count++;
   endtask

   function automatic int clamp_to(input int v, input int lim);
      if (v < 0)
         return 0;
      if (v > lim)
         return lim;
      return v;
   endfunction

   // Advance the circle walk by one item; return 1 when the item yields a span.
   function automatic bit walk_circle(input circle_req_type it, output span_type sp);
      int a, b, p, lft, rgt, row;
      bit end_step, last;
      sp   = '0;
      last = 1'b0;
      if (it.mode == MODE_START) begin
         ctr_col    = $signed(it.center_x);
         ctr_row    = $signed(it.center_y);
         step_x     = 0;
         step_y     = it.radius;
         dec_val    = DEC_INIT - 2 * step_y;
         hold_color = it.draw_color;
         hold_fill  = it.fill_on;
         phase      = 0;
         walking    = 1'b1;
         return 1'b0;
      end
      if (!walking)
         return 1'b0;
      if (hold_fill) begin
         p = phase & 3;
         if (p < 2) begin
            a = step_x;
            b = step_y;
         end else begin
            a = step_y;
            b = step_x;
         end
         if (p & 1)
            b = -b;
         lft      = clamp_to(ctr_col - a, lim_x);
         rgt      = clamp_to(ctr_col + a, lim_x);
         row      = clamp_to(ctr_row + b, lim_y);
         end_step = (p == FILL_LAST_PHASE);
      end else begin
         p = phase & 7;
         if (p < 4) begin
            a = step_x;
            b = step_y;
         end else begin
            a = step_y;
            b = step_x;
         end
         if (p & 1)
            a = -a;
         if (p & 2)
            b = -b;
         lft      = ctr_col + a;
         rgt      = lft;
         row      = ctr_row + b;
         end_step = (p == RING_LAST_PHASE);
      end
      if (end_step) begin
         step_x++;
         if (dec_val >= 0) begin
            step_y--;
            dec_val += 4 * (step_x - step_y) + DEC_DIAG;
         end else begin
            dec_val += 4 * step_x + DEC_AXIS;
         end
         phase = 0;
         if (step_y < step_x) begin
            last    = 1'b1;
            walking = 1'b0;
         end
      end else begin
         phase = (phase + 1) & 7;
      end
      sp.left_x      = lft[CB:0];
      sp.right_x     = rgt[CB:0];
      sp.row_y       = row[CB:0];
      sp.pixel_color = hold_color;
      sp.last_span   = last;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : drive_req
      circle_req_type nxt;
      span_type       sp;
      bit             take_new;
      if (reset) begin
         req_valid  <= 1'b0;
         lim_x      = X_LIMIT_RST;
         lim_y      = Y_LIMIT_RST;
         ctr_col    = 0;
         ctr_row    = 0;
         step_x     = 0;
         step_y     = 0;
         dec_val    = 0;
         phase      = 0;
         hold_color = '0;
         hold_fill  = 1'b0;
         walking    = 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_X_LIMIT: lim_x = csr_wr_data;
               CSR_Y_LIMIT: lim_y = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (walk_circle(cur_req, sp))
               span_q.push_back(sp);
            req_count++;
         end
         // a stalled item holds; otherwise load the next one or idle
         if (!req_valid || !req_stall) begin
            take_new = (pending_q.size() != 0) &&
                       !(pending_q[0].drain && span_q.size() != 0) &&
                       (quiet || $urandom_range(99) >= 6);
            if (take_new) begin
               nxt = pending_q.pop_front();
               cur_req        <= nxt;
               req_mode       <= nxt.mode;
               req_center_x   <= nxt.center_x;
               req_center_y   <= nxt.center_y;
               req_radius     <= nxt.radius;
               req_draw_color <= nxt.draw_color;
               req_fill_on    <= nxt.fill_on;
            end
            req_valid <= take_new;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      span_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (span_q.size() == 0) begin
               flag_error("span with no item waiting for it");
            end else begin
               want = span_q.pop_front();
               if (rsp_left_x !== want.left_x)
                  flag_error($sformatf("left_x got %0d want %0d",
                                       rsp_left_x, $signed(want.left_x)));
               if (rsp_right_x !== want.right_x)
                  flag_error($sformatf("right_x got %0d want %0d",
                                       rsp_right_x, $signed(want.right_x)));
               if (rsp_row_y !== want.row_y)
                  flag_error($sformatf("row_y got %0d want %0d",
                                       rsp_row_y, $signed(want.row_y)));
               if (rsp_pixel_color !== want.pixel_color)
                  flag_error($sformatf("pixel_color got %h want %h",
                                       rsp_pixel_color, want.pixel_color));
               if (rsp_last_span !== want.last_span)
                  flag_error($sformatf("last_span got %b want %b",
                                       rsp_last_span, want.last_span));
            end
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 6);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   function automatic circle_req_type rand_req(input logic mode);
      circle_req_type it;
      it.mode       = mode;
      it.center_x   = CB'($urandom);
      it.center_y   = CB'($urandom);
      it.radius     = (CB-1)'($urandom);
      it.draw_color = COLOR_BITS'($urandom);
      it.fill_on    = 1'($urandom);
      it.drain      = 1'b0;
      return it;
   endfunction

   // center within a few pixels of the visible window
   function automatic logic [CB-1:0] near_edge(input int lim);
      int v;
      v = int'($urandom_range(lim + 20)) - 10;
      if (v > 2047)
         v = 2047;
      return v[CB-1:0];
   endfunction

   task automatic push_req(input circle_req_type it);
      pending_q.push_back(it);
      queued_total++;
   endtask

   // start item, then n_adv advance items with random unused fields
   task automatic queue_run(input logic [CB-1:0] cx, cy, input logic [CB-2:0] r,
                            input logic [COLOR_BITS-1:0] color, input logic fill,
                            input int n_adv, input bit drain);
      circle_req_type it;
      it            = rand_req(MODE_START);
      it.center_x   = cx;
      it.center_y   = cy;
      it.radius     = r;
      it.draw_color = color;
      it.fill_on    = fill;
      it.drain      = drain;
      push_req(it);
      repeat (n_adv)
         push_req(rand_req(MODE_ADVANCE));
   endtask

   task automatic queue_circles(input int budget, input int lx, input int ly);
      circle_req_type it;
      int r, pick, ox, oy, dec, steps, spans, adv;
      while (budget > 0) begin
         pick = $urandom_range(99);
         if (pick < 70)
            r = $urandom_range(15);
         else if (pick < 90)
            r = $urandom_range(60, 16);
         else if (pick < 98)
            r = $urandom_range(2047);
         else
            r = 2047;
         it = rand_req(MODE_START);
         if ($urandom_range(1)) begin
            it.center_x = near_edge(lx);
            it.center_y = near_edge(ly);
         end
         // count walk steps to size a complete run
         ox    = 0;
         oy    = r;
         dec   = DEC_INIT - 2 * r;
         steps = 0;
         do begin
            steps++;
            ox++;
            if (dec >= 0) begin
               oy--;
               dec += 4 * (ox - oy) + DEC_DIAG;
            end else begin
               dec += 4 * ox + DEC_AXIS;
            end
         end while (oy >= ox);
         spans = steps * (it.fill_on ? 4 : 8);
         if (r > 60 || $urandom_range(99) < 20) begin
            // abandon part way; the next start cuts it off
            adv = $urandom_range((spans < 100) ? spans : 100);
            budget -= 1 + adv;
         end else begin
            adv = spans;
            if ($urandom_range(99) < 15)
               adv += $urandom_range(2, 1);
            budget -= 1 + spans;
         end
         queue_run(it.center_x, it.center_y, r[CB-2:0], it.draw_color, it.fill_on,
                   adv, $urandom_range(99) < 2);
      end
   endtask

   task automatic wait_idle();
      while (req_count != queued_total || span_q.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_limits(input logic [CB-1:0] x, y);
      wait_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_X_LIMIT;
      csr_wr_data <= x;
      @(posedge clock);
      csr_index   <= CSR_Y_LIMIT;
      csr_wr_data <= y;
      @(posedge clock);
      csr_index   <= $urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B;
      csr_wr_data <= CB'($urandom);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      fork
         begin
            repeat (5) @(posedge clock);
            reset <= 1'b0;

            // advance with no circle running: dropped
            push_req(rand_req(MODE_ADVANCE));
            // zero radius outline at the coordinate extremes, one spare advance
            queue_run(12'h800, 12'h7FF, '0, 18'h3FFFF, 1'b0, 9, 1'b0);
            // zero radius fill, held back until the outline is drained
            queue_run(12'h7FF, 12'h800, '0, 18'h00000, 1'b1, 4, 1'b1);
            // start while running abandons the outline
            queue_run(12'd100, 12'd100, 11'd5, 18'h2AAAA, 1'b0, 2, 1'b0);
            // unit fill clamped on the left and bottom edges
            queue_run(-12'sd5, 12'd250, 11'd1, 18'h15555, 1'b1, 4, 1'b0);
            queue_circles(400, X_LIMIT_RST, Y_LIMIT_RST);

            write_limits('0, '0);
            queue_circles(350, 0, 0);

            write_limits('1, '1);
            quiet = 1'b1;
            queue_circles(400, 4095, 4095);
            wait_idle();
            quiet = 1'b0;

            begin : mid_limits
               logic [CB-1:0] lx, ly;
               lx = CB'($urandom);
               ly = CB'($urandom);
               write_limits(lx, ly);
               queue_circles(400, lx, ly);
               lx = CB'($urandom_range(63));
               ly = CB'($urandom_range(63));
               write_limits(lx, ly);
               queue_circles(400, lx, ly);
            end

            wait_idle();
            repeat (10) @(posedge clock);
         end
         wait (stuck_cycles >= STUCK_LIMIT);
      join_any
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("no handshake for %0d cycles, %0d spans outstanding",
                  stuck_cycles, span_q.size());
         $display("status: fail");
      end else if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mcsg_pkg.sv
hdl/mcsg_csr.sv
hdl/mcsg_walk.sv
hdl/midpoint_circle_span_generator.sv
hdl/mcsg_checker.sv
dv/tb.sv
